// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hw/rtl/b64d_pkg.sv
// types, constants and the character classifier of the base64 text decoder
// no dependencies
package b64d_pkg;

   typedef enum logic [1:0] {
      CHAR_VALUE,
      CHAR_SKIP,
      CHAR_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    value;
   } sextet_type;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   localparam logic [5:0] PLUS_VALUE   = 6'd62;
   localparam logic [5:0] SLASH_VALUE  = 6'd63;
   localparam logic [7:0] LOWER_OFFSET = 8'd26;
   localparam logic [7:0] DIGIT_OFFSET = 8'd52;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // one accepted character's results: up to three bytes or one end marker
   typedef struct packed {
      logic [1:0]      last_idx;
      logic [2:0][7:0] bytes;
      logic            is_data;
      logic            done;
      logic            early;
      logic [15:0]     base;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.kind  = CHAR_VALUE;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
      end else if (c == CHAR_PLUS) begin
         s.value = PLUS_VALUE;
      end else if (c == CHAR_SLASH) begin
         s.value = SLASH_VALUE;
      end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
         s.kind = CHAR_SKIP;
      end else begin
         s.kind = CHAR_BAD;
      end
      return s;
   endfunction

endpackage

// File: hw/rtl/b64d_front.sv
// front end: accepts characters, classifies them, keeps the decode state
// and pushes each character's results into the queue; depends on b64d_pkg
module b64d_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [15:0]               csr_data,
   input  b64d_pkg::queue_status_type q_status,
   output logic                      push,
   output b64d_pkg::queue_entry_type push_entry
);
   import b64d_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 1;

   logic [15:0]           capacity_ff, capacity_in;
   logic [17:0]           acc_ff, acc_in;
   logic [1:0]            count_ff, count_in;
   logic [COUNT_BITS-1:0] produced_ff, produced_in;
   logic                  halted_ff, halted_in;

   sextet_type  sx;
   logic        accept;
   logic [17:0] acc_1;
   logic [1:0]  count_1;
   logic        halt_1, halt_2, group;
   logic [23:0] acc_full;
   logic [CMP_W-1:0] cap_w, prod_w, room_w;
   logic [1:0]  want, take;

   assign req_tready = !q_status.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sx       = sextet_of(req_tdata);
      acc_1    = acc_ff;
      count_1  = count_ff;
      halt_1   = halted_ff;
      group    = 1'b0;
      acc_full = {acc_ff[17:0], sx.value};
      if (!halted_ff) begin
         case (sx.kind)
            CHAR_BAD: begin
               halt_1 = 1'b1;
            end
            CHAR_VALUE: begin
               if (count_ff == 2'd3) begin
                  group   = 1'b1;
                  acc_1   = '0;
                  count_1 = '0;
               end else begin
                  acc_1   = {acc_ff[11:0], sx.value};
                  count_1 = count_ff + 2'd1;
               end
            end
            default: begin
            end
         endcase
      end

      cap_w  = CMP_W'(capacity_ff);
      prod_w = CMP_W'(produced_ff);
      room_w = (cap_w > prod_w) ? (cap_w - prod_w) : '0;

      want = 2'd0;
      if (group) begin
         want = 2'd3;
      end else if (req_tlast) begin
         if (count_1 == 2'd3) begin
            want = 2'd2;
         end else if (count_1 == 2'd2) begin
            want = 2'd1;
         end
      end
      take   = (room_w >= CMP_W'(want)) ? want : room_w[1:0];
      halt_2 = halt_1 || (take != want);

      // an end marker carries a zero byte
      push_entry.bytes = '0;
      if (take != 2'd0) begin
         if (group) begin
            push_entry.bytes[0] = acc_full[23:16];
            push_entry.bytes[1] = acc_full[15:8];
            push_entry.bytes[2] = acc_full[7:0];
         end else if (count_1 == 2'd3) begin
            push_entry.bytes[0] = acc_1[17:10];
            push_entry.bytes[1] = acc_1[9:2];
         end else begin
            push_entry.bytes[0] = acc_1[11:4];
         end
      end
      push_entry.last_idx = (take == 2'd0) ? 2'd0 : take - 2'd1;
      push_entry.is_data  = (take != 2'd0);
      push_entry.done     = req_tlast;
      push_entry.early    = halt_2;
      push_entry.base     = prod_w[15:0];

      push = accept && (take != 2'd0 || req_tlast);

      acc_in      = acc_ff;
      count_in    = count_ff;
      produced_in = produced_ff;
      halted_in   = halted_ff;
      if (accept) begin
         if (req_tlast) begin
            acc_in      = '0;
            count_in    = '0;
            produced_in = '0;
            halted_in   = 1'b0;
         end else begin
            acc_in      = acc_1;
            count_in    = count_1;
            produced_in = produced_ff + COUNT_BITS'(take);
            halted_in   = halt_2;
         end
      end

      capacity_in = csr_valid ? csr_data : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         acc_ff      <= '0;
         count_ff    <= '0;
         produced_ff <= '0;
         halted_ff   <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         produced_ff <= produced_in;
         halted_ff   <= halted_in;
      end
   end

endmodule

// File: hw/rtl/b64d_queue.sv
// result queue between front and back, four entries of per-character results
// depends on b64d_pkg
module b64d_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64d_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output b64d_pkg::queue_entry_type  head,
   output b64d_pkg::queue_status_type status
);
   import b64d_pkg::*;

   queue_entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   fill_ff, fill_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/b64d_back.sv
// back end: unpacks queue entries into single results behind an output register
// depends on b64d_pkg
module b64d_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  b64d_pkg::queue_entry_type  head,
   input  b64d_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // data_byte, bytes_total
   output logic [1:0]                 rsp_tuser,  // byte_valid, ended_early
   output logic                       rsp_tlast
);
   import b64d_pkg::*;

   localparam logic [15:0] TOTAL_MASK =
      (COUNT_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << COUNT_BITS) - 64'd1);

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] data_ff;
   logic [1:0]  user_ff;
   logic        last_ff;
   logic        load;
   logic [15:0] total;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      load     = !status.empty && (!valid_ff || rsp_tready);
      pop      = load && (idx_ff == head.last_idx);
      total    = (head.base + (head.is_data ? 16'(idx_ff) + 16'd1 : 16'd0)) & TOTAL_MASK;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = pop ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {total, head.bytes[idx_ff]};
         user_ff <= {head.early, head.is_data};
         last_ff <= head.done && pop;
      end
   end

endmodule

// File: hw/rtl/base64_text_decoder.sv
// base64 text decoder top level: front end, result queue and back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
//
// usage
//   req channel: one character per transfer in req_tdata, req_tlast on the
//     last character of a text. csr channel: csr_data is the byte capacity
//     per text, always ready, to be written only while the block is idle; the block does not enforce this.
//   rsp channel: one result per transfer, rsp_tdata = {bytes_total, data_byte},
//     rsp_tuser = {ended_early, byte_valid}, rsp_tlast on the last result of
//     a text. a text that yields no byte ends with one marker, byte_valid 0.
//   path: the results of a character pass through the queue and then the
//     output register; further results follow one per cycle while the
//     receiver takes them.
//   throughput: one character per cycle and one result per cycle while
//     the receiver takes results; a full group puts one entry of three
//     results into the four-entry queue, which the back end drains one
//     result per cycle, so req_tready drops only when the queue fills.
//   reset: clears decode state and queue, capacity returns to 65535.
//   receiver stall: the output register holds its result, the queue fills,
//     then req_tready goes low until the receiver takes results again.
module base64_text_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // text_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // data_byte, bytes_total
   output logic [1:0]  rsp_tuser,  // byte_valid, ended_early
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import b64d_pkg::*;

   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head;
   logic             push;
   logic             pop;

   b64d_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   b64d_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/b64d_checker.sv
// port-level checks for the base64 text decoder, bound to the top level
// depends on assert_macros.svh and base64_text_decoder
`include "assert_macros.svh"

module b64d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // an end marker closes the text
   `ASSERT_IMPLIES(a_marker_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast, "end marker without tlast")

   // an end marker carries a zero byte
   `ASSERT_IMPLIES(a_marker_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[7:0] == 8'h00, "end marker with nonzero byte")

   // no result right after reset
   `ASSERT_IMPLIES(a_reset_idle, clock, 1'b0, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind base64_text_decoder b64d_checker u_checker (.*);
